### hdl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg: constants and helpers for the PLL divider search unit
// Holds the synthesizer constants, search bounds and dead zone handling.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int unsigned FREQ_W   = 18;
    localparam int unsigned VCO_W    = 22;
    localparam int unsigned DIV_W    = 6;
    localparam int unsigned POST_W   = 2;
    localparam int unsigned NUM_W    = 23;
    localparam int unsigned DEN_W    = 5;
    localparam int unsigned STEP_W   = 5;
    localparam int unsigned SHIFT_W  = FREQ_W + 3;

    // Reference frequency times eight, in kHz.
    localparam logic [NUM_W-1:0]   REF_SCALED  = 23'd114544;
    // Numerator at the first reference divider, REF_SCALED * (65 - 1).
    localparam logic [NUM_W-1:0]   NUM_FIRST   = 23'd7330816;
    localparam logic [6:0]         DIV_BASE    = 7'd65;

    localparam logic [SHIFT_W-1:0] VCO_LOW     = 21'd110000;
    localparam logic [SHIFT_W-1:0] VCO_HIGH    = 21'd220000;
    localparam logic [FREQ_W-1:0]  DIST_START  = 18'd250000;

    localparam logic [DIV_W-1:0]   N_FIRST     = 6'd40;
    localparam logic [DIV_W-1:0]   N_LAST      = 6'd62;
    localparam logic [DIV_W-1:0]   M_FIRST     = 6'd1;
    localparam logic [DIV_W-1:0]   M_LAST      = 6'd62;
    localparam logic [POST_W-1:0]  P_LAST      = 2'd3;

    localparam logic [STEP_W-1:0]  DIV_STEPS_LAST = 5'(NUM_W - 1);

    // Moves a target out of the two frequency bands the synthesizer cannot hit.
    function automatic logic [FREQ_W-1:0] leave_dead_zones(input logic [FREQ_W-1:0] f);
        logic [FREQ_W-1:0] r;
        r = f;
        if (f > 18'd55000 && f < 18'd57250)
        begin
            r = (f > 18'd56125) ? 18'd57350 : 18'd54900;
        end
        else if (f > 18'd114000 && f < 18'd119000)
        begin
            r = (f > 18'd116500) ? 18'd119150 : 18'd112500;
        end
        return r;
    endfunction

endpackage

### hdl/pll_divider_search_unit.sv
// ----------------------------------------------------------------------------
// pll_divider_search_unit: divider search for an N/M/P clock synthesizer
// Finds the n, m, p triple whose output comes closest to a requested frequency.
//
//   channel   ports                                          handshake
//   request   target_freq                                    start, busy
//   result    found, n_div, m_div, post_div, actual_freq     done
//
// busy is high from the cycle after acceptance through the done cycle. The
// sequencer checks each post divider in turn (at most four) and sweeps every n
// and m for each post divider whose shifted target lies in the VCO range (at
// most two). For every n a bit-serial divider runs two 23-bit divisions; the
// m sweep then steps the quotient by a subtract of the precomputed increment,
// one m a cycle. Reset clears the sequencer; the result strobe done lasts one
// cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module pll_divider_search_unit
    import pds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FREQ_W-1:0]   target_freq,
    output logic                done,
    output logic                found,
    output logic [DIV_W-1:0]    n_div,
    output logic [DIV_W-1:0]    m_div,
    output logic [POST_W-1:0]   post_div,
    output logic [VCO_W-1:0]    actual_freq
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PCHECK,
        ST_DIV_BASE,
        ST_DIV_STEP,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [FREQ_W-1:0]   f_reg;
    logic [FREQ_W-1:0]   shifted_reg;
    logic [POST_W-1:0]   p_reg;
    logic [DIV_W-1:0]    n_reg;
    logic [DIV_W-1:0]    m_reg;

    // Bit-serial divider.
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   cnt_reg;

    // Running quotient and remainder of the m sweep, and the step per m.
    logic [VCO_W-1:0]    q_reg;
    logic [DEN_W-1:0]    r_reg;
    logic [VCO_W-1:0]    qa_reg;
    logic [DEN_W-1:0]    ra_reg;

    // Best candidate so far.
    logic [FREQ_W-1:0]   best_reg;
    logic                hit_reg;
    logic [DIV_W-1:0]    bn_reg;
    logic [DIV_W-1:0]    bm_reg;
    logic [POST_W-1:0]   bp_reg;
    logic [VCO_W-1:0]    bq_reg;

    logic [DEN_W-1:0]    den;
    logic [DEN_W:0]      rem_shift;
    logic                q_bit;
    logic [DEN_W-1:0]    rem_next;
    logic [NUM_W-1:0]    quo_next;
    logic [SHIFT_W-1:0]  sh_full;
    logic                p_ok;
    logic [VCO_W-1:0]    cand_dist;
    logic                borrow;
    logic [VCO_W-1:0]    q_next;
    logic [DEN_W-1:0]    r_next;

    assign den = DEN_W'(DIV_BASE - {1'b0, n_reg});

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        q_bit     = (rem_shift >= {1'b0, den});
        rem_next  = q_bit ? DEN_W'(rem_shift - {1'b0, den}) : rem_shift[DEN_W-1:0];
        quo_next  = {quo_reg[NUM_W-2:0], q_bit};
    end

    always_comb
    begin
        sh_full = SHIFT_W'(f_reg) << p_reg;
        p_ok    = (sh_full >= VCO_LOW) && ((p_reg == '0) || (sh_full <= VCO_HIGH));
    end

    always_comb
    begin
        if (q_reg >= VCO_W'(shifted_reg))
        begin
            cand_dist = q_reg - VCO_W'(shifted_reg);
        end
        else
        begin
            cand_dist = VCO_W'(shifted_reg) - q_reg;
        end
        // Moving to the next m takes REF_SCALED off the numerator.
        borrow = (r_reg < ra_reg);
        if (borrow)
        begin
            q_next = q_reg - qa_reg - VCO_W'(1);
            r_next = DEN_W'({1'b0, r_reg} + {1'b0, den} - {1'b0, ra_reg});
        end
        else
        begin
            q_next = q_reg - qa_reg;
            r_next = r_reg - ra_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            f_reg       <= '0;
            shifted_reg <= '0;
            p_reg       <= '0;
            n_reg       <= N_FIRST;
            m_reg       <= M_FIRST;
            num_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            q_reg       <= '0;
            r_reg       <= '0;
            qa_reg      <= '0;
            ra_reg      <= '0;
            best_reg    <= DIST_START;
            hit_reg     <= 1'b0;
            bn_reg      <= '0;
            bm_reg      <= '0;
            bp_reg      <= '0;
            bq_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        f_reg     <= leave_dead_zones(target_freq);
                        p_reg     <= '0;
                        best_reg  <= DIST_START;
                        hit_reg   <= 1'b0;
                        bn_reg    <= '0;
                        bm_reg    <= '0;
                        bp_reg    <= '0;
                        bq_reg    <= '0;
                        state_reg <= ST_PCHECK;
                    end
                end

                ST_PCHECK:
                begin
                    if (p_ok)
                    begin
                        shifted_reg <= sh_full[FREQ_W-1:0];
                        n_reg       <= N_FIRST;
                        num_reg     <= NUM_FIRST;
                        rem_reg     <= '0;
                        cnt_reg     <= '0;
                        state_reg   <= ST_DIV_BASE;
                    end
                    else if (p_reg == P_LAST)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        p_reg <= p_reg + POST_W'(1);
                    end
                end

                ST_DIV_BASE:
                begin
                    if (cnt_reg == DIV_STEPS_LAST)
                    begin
                        // Quotient and remainder for the first m.
                        q_reg     <= quo_next[VCO_W-1:0];
                        r_reg     <= rem_next;
                        num_reg   <= REF_SCALED;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_STEP;
                    end
                    else
                    begin
                        num_reg <= num_reg << 1;
                        quo_reg <= quo_next;
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg + STEP_W'(1);
                    end
                end

                ST_DIV_STEP:
                begin
                    num_reg <= num_reg << 1;
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + STEP_W'(1);
                    if (cnt_reg == DIV_STEPS_LAST)
                    begin
                        qa_reg    <= quo_next[VCO_W-1:0];
                        ra_reg    <= rem_next;
                        m_reg     <= M_FIRST;
                        state_reg <= ST_SEARCH;
                    end
                end

                ST_SEARCH:
                begin
                    if (cand_dist < VCO_W'(best_reg))
                    begin
                        best_reg <= cand_dist[FREQ_W-1:0];
                        hit_reg  <= 1'b1;
                        bn_reg   <= n_reg;
                        bm_reg   <= m_reg;
                        bp_reg   <= p_reg;
                        bq_reg   <= q_reg;
                    end
                    q_reg <= q_next;
                    r_reg <= r_next;
                    if (m_reg == M_LAST)
                    begin
                        if (n_reg == N_LAST)
                        begin
                            if (p_reg == P_LAST)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                p_reg     <= p_reg + POST_W'(1);
                                state_reg <= ST_PCHECK;
                            end
                        end
                        else
                        begin
                            n_reg     <= n_reg + DIV_W'(1);
                            num_reg   <= NUM_FIRST;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV_BASE;
                        end
                    end
                    else
                    begin
                        m_reg <= m_reg + DIV_W'(1);
                    end
                end

                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The best fields stay zero when no candidate was accepted.
    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_DONE);
    assign found       = hit_reg;
    assign n_div       = bn_reg;
    assign m_div       = bm_reg;
    assign post_div    = bp_reg;
    assign actual_freq = bq_reg >> bp_reg;

endmodule

### verif/pll_divider_search_unit_tb.sv
// ----------------------------------------------------------------------------
// pll_divider_search_unit_tb: self-checking bench for the PLL divider search
// Sends target frequencies through the start/busy handshake. Each one comes
// from a table of edge cases or from a random mix weighted toward the VCO
// limits and the dead zones. Every result on done is checked field by field
// against a fixed table choice or an independent search of all n, m, p triples.
// ----------------------------------------------------------------------------
module pll_divider_search_unit_tb
    import pds_pkg::*;
();

    typedef struct packed {
        logic               found;
        logic [DIV_W-1:0]   n_div;
        logic [DIV_W-1:0]   m_div;
        logic [POST_W-1:0]  post_div;
        logic [VCO_W-1:0]   actual_freq;
    } divider_choice_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  target;
        logic               typed;
        divider_choice_t    choice;
    } request_row_t;

    localparam divider_choice_t NO_CHOICE = '0;

    localparam int unsigned SYNTH_REF_X8  = 114544;
    localparam int unsigned VCO_MIN_KHZ   = 110000;
    localparam int unsigned VCO_MAX_KHZ   = 220000;
    localparam int unsigned DIST_LIMIT    = 250000;
    localparam int          RANDOM_ITEMS  = 75;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FREQ_W-1:0]  target_freq = '0;
    logic               done;
    logic               found;
    logic [DIV_W-1:0]   n_div;
    logic [DIV_W-1:0]   m_div;
    logic [POST_W-1:0]  post_div;
    logic [VCO_W-1:0]   actual_freq;

    divider_choice_t    pending_choices[$];
    int                 fail_count = 0;
    int                 items_sent = 0;
    int                 results_checked = 0;
    int                 results_found = 0;

    pll_divider_search_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .target_freq (target_freq),
        .done        (done),
        .found       (found),
        .n_div       (n_div),
        .m_div       (m_div),
        .post_div    (post_div),
        .actual_freq (actual_freq)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exhaustive search in the same visiting order as the hardware; only a
    // strictly closer candidate replaces the one already kept.
    function automatic divider_choice_t best_divider_choice(input logic [FREQ_W-1:0] target);
        int unsigned     f;
        int unsigned     shifted;
        int unsigned     vco;
        int unsigned     delta;
        int unsigned     closest;
        int              p;
        int              n;
        int              m;
        divider_choice_t c;
        f = target;
        if (f > 55000 && f < 57250)
        begin
            f = (f > 56125) ? 57350 : 54900;
        end
        else if (f > 114000 && f < 119000)
        begin
            f = (f > 116500) ? 119150 : 112500;
        end
        closest = DIST_LIMIT;
        c = NO_CHOICE;
        for (p = 0; p < 4; p++)
        begin
            shifted = f << p;
            // The upper VCO limit does not apply without a post divider.
            if (shifted >= VCO_MIN_KHZ && (p == 0 || shifted <= VCO_MAX_KHZ))
            begin
                for (n = 40; n <= 62; n++)
                begin
                    for (m = 1; m <= 62; m++)
                    begin
                        vco = (SYNTH_REF_X8 * (65 - m)) / (65 - n);
                        delta = (vco >= shifted) ? vco - shifted : shifted - vco;
                        if (delta < closest)
                        begin
                            closest = delta;
                            c.found = 1'b1;
                            c.n_div = DIV_W'(n);
                            c.m_div = DIV_W'(m);
                            c.post_div = POST_W'(p);
                            c.actual_freq = VCO_W'(vco >> p);
                        end
                    end
                end
            end
        end
        return c;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_result
        divider_choice_t want;
        if (rst_n && done)
        begin
            if (pending_choices.size() == 0)
            begin
                $error("result item with no request outstanding: found %0d n %0d m %0d",
                       found, n_div, m_div);
                fail_count++;
            end
            else
            begin
                want = pending_choices.pop_front();
                results_checked++;
                if (found === 1'b1)
                    results_found++;
                check_field("found", 32'(want.found), 32'(found));
                check_field("n_div", 32'(want.n_div), 32'(n_div));
                check_field("m_div", 32'(want.m_div), 32'(m_div));
                check_field("post_div", 32'(want.post_div), 32'(post_div));
                check_field("actual_freq", 32'(want.actual_freq), 32'(actual_freq));
            end
        end
    end

    // Called at a falling edge. A nonzero gap drops start, lets the block
    // finish the current item and then idles; a zero gap keeps start high.
    task automatic issue_request(input logic [FREQ_W-1:0] f, input int gap,
                                 input logic typed, input divider_choice_t typed_choice);
        if (gap > 0)
        begin
            start <= 1'b0;
            while (busy)
                @(negedge clk);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        target_freq <= f;
        do
            @(posedge clk);
        while (busy);
        pending_choices.push_back(typed ? typed_choice : best_divider_choice(f));
        items_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        request_row_t       rows[$];
        logic [FREQ_W-1:0]  f;
        int                 gap;
        int                 edge_khz;
        int                 i;

        // Targets too low for any post divider give no triple at all.
        rows.push_back('{18'd0,      1'b1, NO_CHOICE});
        rows.push_back('{18'd1,      1'b1, NO_CHOICE});
        rows.push_back('{18'd13749,  1'b1, NO_CHOICE});
        rows.push_back('{18'd13750,  1'b0, NO_CHOICE});
        rows.push_back('{18'd27499,  1'b0, NO_CHOICE});
        rows.push_back('{18'd27500,  1'b0, NO_CHOICE});
        rows.push_back('{18'd54999,  1'b0, NO_CHOICE});
        rows.push_back('{18'd55000,  1'b0, NO_CHOICE});
        rows.push_back('{18'd55001,  1'b0, NO_CHOICE});
        rows.push_back('{18'd56125,  1'b0, NO_CHOICE});
        rows.push_back('{18'd56126,  1'b0, NO_CHOICE});
        rows.push_back('{18'd57249,  1'b0, NO_CHOICE});
        rows.push_back('{18'd57250,  1'b0, NO_CHOICE});
        rows.push_back('{18'd109999, 1'b0, NO_CHOICE});
        rows.push_back('{18'd110000, 1'b0, NO_CHOICE});
        rows.push_back('{18'd110001, 1'b0, NO_CHOICE});
        rows.push_back('{18'd114000, 1'b0, NO_CHOICE});
        rows.push_back('{18'd114001, 1'b0, NO_CHOICE});
        rows.push_back('{18'd116500, 1'b0, NO_CHOICE});
        rows.push_back('{18'd116501, 1'b0, NO_CHOICE});
        rows.push_back('{18'd118999, 1'b0, NO_CHOICE});
        rows.push_back('{18'd119000, 1'b0, NO_CHOICE});
        rows.push_back('{18'd220000, 1'b0, NO_CHOICE});
        rows.push_back('{18'd131071, 1'b0, NO_CHOICE});
        rows.push_back('{18'd262143, 1'b0, NO_CHOICE});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < rows.size(); i++)
        begin
            gap = $urandom_range(0, 14);
            issue_request(rows[i].target, gap, rows[i].typed, rows[i].choice);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: f = FREQ_W'($urandom);
                4:          f = FREQ_W'($urandom_range(55000, 57250));
                5:          f = FREQ_W'($urandom_range(114000, 119000));
                6, 7:
                begin
                    case ($urandom_range(0, 5))
                        0:       edge_khz = 13750;
                        1:       edge_khz = 27500;
                        2:       edge_khz = 55000;
                        3:       edge_khz = 56125;
                        4:       edge_khz = 110000;
                        default: edge_khz = 116500;
                    endcase
                    f = FREQ_W'(edge_khz - 20 + $urandom_range(0, 40));
                end
                8:          f = FREQ_W'($urandom_range(0, 13749));
                default:    f = FREQ_W'($urandom_range(110000, 262143));
            endcase
            // One stretch runs back to back with start held high.
            gap = (i >= 30 && i < 50) ? 0 : $urandom_range(0, 14);
            issue_request(f, gap, 1'b0, NO_CHOICE);
        end

        start <= 1'b0;
        while (pending_choices.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d target frequencies (%0d from the edge-case table), checked %0d results,",
                 items_sent, rows.size(), results_checked);
        $display("of which %0d found a divider triple and %0d found none.",
                 results_found, results_checked - results_found);
        if (fail_count == 0)
            $display("pll_divider_search_unit regression: pass");
        else
            $display("pll_divider_search_unit regression: fail");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("Timed out with %0d results still outstanding.", pending_choices.size());
        $display("pll_divider_search_unit regression: fail");
        $finish;
    end

endmodule
